// ===== rtl/core/first_fit_free_list_allocator_top_assert.svh =====
// Assertion macros for the first-fit allocator
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// property that holds whenever reset is released
`define FFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication shorthand
`define FFA_IMPLY(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ffa_pkg.sv =====
package ffa_pkg;
    localparam int TableEntries = 64;
    localparam int IdxW = $clog2(TableEntries);
    localparam int CntW = $clog2(TableEntries + 1);

    typedef enum logic [1:0] {OP_ALLOC = 2'd0, OP_FREE = 2'd1, OP_CLEAR = 2'd2,
                              OP_RSVD = 2'd3} op_t;
    typedef enum logic [1:0] {ST_OK = 2'd0, ST_NOFIT = 2'd1, ST_LOST = 2'd2,
                              ST_RSVD = 2'd3} status_t;

    // memory command from the sequencer
    typedef struct packed {
        logic            rd_en;
        logic [IdxW-1:0] rd_idx;
        logic            wr_en;
        logic [IdxW-1:0] wr_idx;
        logic [31:0]     wr_start;
        logic [31:0]     wr_size;
    } mem_cmd_t;
endpackage

// ===== rtl/core/ffa_table.sv =====
module ffa_table (
    input  logic             clk,
    input  ffa_pkg::mem_cmd_t cmd,
    output logic [31:0]      rd_start,
    output logic [31:0]      rd_size
);
    import ffa_pkg::*;

    logic [31:0] start_mem [TableEntries];
    logic [31:0] size_mem  [TableEntries];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            start_mem[cmd.wr_idx] <= cmd.wr_start;
            size_mem[cmd.wr_idx]  <= cmd.wr_size;
        end
        if (cmd.rd_en)
        begin
            rd_start <= start_mem[cmd.rd_idx];
            rd_size  <= size_mem[cmd.rd_idx];
        end
    end
endmodule

// ===== rtl/core/ffa_seq.sv =====
module ffa_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [31:0]       extent_address,
    input  logic [31:0]       byte_count,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       granted_address,
    output logic [1:0]        status,
    output logic [6:0]        entries_used,
    output logic [6:0]        peak_entries,
    output logic [31:0]       lost_events,
    output logic [31:0]       lost_bytes,
    output logic [31:0]       free_bytes_total,
    output ffa_pkg::mem_cmd_t cmd,
    input  logic [31:0]       rd_start,
    input  logic [31:0]       rd_size
);
    import ffa_pkg::*;

    // RD issues read of idx_reg, CHK examines the data in the next cycle.
    typedef enum logic [3:0] {
        S_IDLE, S_ARD, S_ACHK, S_FRD, S_FCHK, S_FUP, S_FUPCHK,
        S_RMRD, S_RMWR, S_INRD, S_INWR, S_DONE
    } state_t;

    state_t          state_reg;
    logic [31:0]     addr_reg, cnt_reg;
    logic [CntW-1:0] idx_reg;      // scan / shift index
    logic [CntW-1:0] pos_reg;      // insert position
    logic [CntW-1:0] count_reg, peak_reg;
    logic [31:0]     lost_reg, lostb_reg, sum_reg;
    logic [31:0]     lo_start_reg, lo_size_reg;
    logic            lo_ok_reg;
    logic [31:0]     grant_reg;
    logic [1:0]      st_reg;
    logic            ovalid_reg;

    logic [CntW-1:0] idx_m1;
    logic [32:0]     lostb_add;
    assign idx_m1    = idx_reg - CntW'(1);
    assign lostb_add = {1'b0, lostb_reg} + {1'b0, cnt_reg};

    assign in_stall = (state_reg != S_IDLE) || ovalid_reg;
    assign out_valid = ovalid_reg;
    assign granted_address = grant_reg;
    assign status = st_reg;
    assign entries_used = 7'(count_reg);
    assign peak_entries = 7'(peak_reg);
    assign lost_events = lost_reg;
    assign lost_bytes = lostb_reg;
    assign free_bytes_total = sum_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_ARD, S_FRD, S_FUP, S_RMRD, S_INRD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_idx = IdxW'(state_reg == S_INRD ? idx_m1 : idx_reg);
            end
            default: ;
        endcase
        unique case (state_reg)
            S_RMWR:
            begin
                cmd.wr_en = 1'b1; cmd.wr_idx = IdxW'(idx_m1);
                cmd.wr_start = rd_start; cmd.wr_size = rd_size;
            end
            S_INWR:
            begin
                cmd.wr_en = 1'b1; cmd.wr_idx = IdxW'(idx_reg);
                cmd.wr_start = rd_start; cmd.wr_size = rd_size;
            end
            default: ;
        endcase
        // single-cycle writes issued from check states and from the last insert step
        if (state_reg == S_ACHK && rd_size >= cnt_reg)
        begin
            cmd.wr_en = 1'b1; cmd.wr_idx = IdxW'(idx_reg);
            cmd.wr_start = rd_start + cnt_reg; cmd.wr_size = rd_size - cnt_reg;
        end
        if (state_reg == S_FUPCHK)
        begin
            cmd.wr_en = 1'b1;
            if (lo_ok_reg)
            begin
                cmd.wr_idx = IdxW'(idx_m1);
                cmd.wr_start = lo_start_reg;
                cmd.wr_size = lo_size_reg + cnt_reg +
                    ((idx_reg < count_reg && addr_reg + cnt_reg == rd_start) ? rd_size : 32'd0);
            end
            else if (idx_reg < count_reg && addr_reg + cnt_reg == rd_start)
            begin
                cmd.wr_idx = IdxW'(idx_reg);
                cmd.wr_start = addr_reg; cmd.wr_size = rd_size + cnt_reg;
            end
            else
                cmd.wr_en = 1'b0;
        end
        if (state_reg == S_INRD && idx_reg == pos_reg)
        begin
            cmd.rd_en = 1'b0;
            cmd.wr_en = 1'b1; cmd.wr_idx = IdxW'(pos_reg);
            cmd.wr_start = addr_reg; cmd.wr_size = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0; peak_reg <= '0;
            lost_reg <= '0; lostb_reg <= '0; sum_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && !in_stall)
                    begin
                        addr_reg <= extent_address;
                        cnt_reg <= byte_count; idx_reg <= '0;
                        grant_reg <= '0; st_reg <= ST_OK; lo_ok_reg <= 1'b0;
                        unique case (op_t'(operation))
                            OP_ALLOC: state_reg <= S_ARD;
                            OP_FREE:  state_reg <= S_FRD;
                            OP_CLEAR:
                            begin
                                count_reg <= '0; peak_reg <= '0; lost_reg <= '0;
                                lostb_reg <= '0; sum_reg <= '0; state_reg <= S_DONE;
                            end
                            default:  state_reg <= S_DONE;
                        endcase
                    end
                S_ARD:
                    if (idx_reg >= count_reg)
                    begin
                        st_reg <= ST_NOFIT; state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_ACHK;
                S_ACHK:
                    if (rd_size >= cnt_reg)
                    begin
                        grant_reg <= rd_start;
                        sum_reg <= sum_reg - cnt_reg;
                        if (rd_size == cnt_reg)
                        begin
                            count_reg <= count_reg - CntW'(1);
                            idx_reg <= idx_reg + CntW'(1);
                            state_reg <= S_RMRD;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CntW'(1); state_reg <= S_ARD;
                    end
                S_FRD:
                    if (idx_reg >= count_reg)
                        state_reg <= S_FUP;
                    else
                        state_reg <= S_FCHK;
                S_FCHK:
                    if (rd_start > addr_reg)
                        state_reg <= S_FUP;
                    else
                    begin
                        lo_ok_reg <= (rd_start + rd_size == addr_reg);
                        lo_start_reg <= rd_start; lo_size_reg <= rd_size;
                        idx_reg <= idx_reg + CntW'(1); state_reg <= S_FRD;
                    end
                S_FUP: state_reg <= S_FUPCHK;
                S_FUPCHK:
                    if (lo_ok_reg)
                    begin
                        sum_reg <= sum_reg + cnt_reg;
                        if (idx_reg < count_reg && addr_reg + cnt_reg == rd_start)
                        begin
                            count_reg <= count_reg - CntW'(1);
                            idx_reg <= idx_reg + CntW'(1);
                            state_reg <= S_RMRD;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                    else if (idx_reg < count_reg && addr_reg + cnt_reg == rd_start)
                    begin
                        sum_reg <= sum_reg + cnt_reg; state_reg <= S_DONE;
                    end
                    else if (count_reg < CntW'(TableEntries))
                    begin
                        pos_reg <= idx_reg; idx_reg <= count_reg;
                        count_reg <= count_reg + CntW'(1);
                        if (peak_reg <= count_reg)
                            peak_reg <= count_reg + CntW'(1);
                        sum_reg <= sum_reg + cnt_reg;
                        state_reg <= S_INRD;
                    end
                    else
                    begin
                        st_reg <= ST_LOST;
                        if (lost_reg != '1)
                            lost_reg <= lost_reg + 32'd1;
                        lostb_reg <= lostb_add[32] ? '1 : lostb_add[31:0];
                        state_reg <= S_DONE;
                    end
                // shift entries down: idx_reg is source, idx-1 destination
                S_RMRD:
                    if (idx_reg > count_reg)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_RMWR;
                S_RMWR:
                begin
                    idx_reg <= idx_reg + CntW'(1); state_reg <= S_RMRD;
                end
                // shift entries up: read idx-1, write idx
                S_INRD:
                    if (idx_reg == pos_reg)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_INWR;
                S_INWR:
                begin
                    idx_reg <= idx_m1; state_reg <= S_INRD;
                end
                S_DONE:
                begin
                    ovalid_reg <= 1'b1; state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/first_fit_free_list_allocator_top.sv =====
// First-fit free-extent allocator.
// Input channel: in_valid/in_stall with operation (0 alloc, 1 free, 2 clear),
// extent_address and byte_count. Output channel: out_valid/out_stall, one
// result beat per input beat: granted_address, status, and the counters.
// A single-port table of 64 extents is walked by one sequencer, at most one
// entry read or written per cycle. Clear and reserved ops go straight to the
// result. Alloc scans up to the first fit and free up to the first entry
// above the freed address, or to the end. Removing or inserting an entry
// shifts the entries behind it; scan and shift together cover the table once.
// One item is in flight at a time; in_stall stays high from acceptance
// until the result beat has been taken, and the next beat can be taken the
// cycle after that.
// Reset clears the entry count and all counters; table contents need no
// clearing since only entries below the count are used.
// While out_stall is high the result beat holds and no new beat is taken.
module first_fit_free_list_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [31:0] extent_address,
    input  logic [31:0] byte_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] granted_address,
    output logic [1:0]  status,
    output logic [6:0]  entries_used,
    output logic [6:0]  peak_entries,
    output logic [31:0] lost_events,
    output logic [31:0] lost_bytes,
    output logic [31:0] free_bytes_total
);
    import ffa_pkg::*;

    `include "first_fit_free_list_allocator_top_assert.svh"

    mem_cmd_t    cmd;
    logic [31:0] rd_start, rd_size;

    ffa_seq u_seq (
        .clk, .rst_n, .in_valid, .in_stall, .operation, .extent_address,
        .byte_count, .out_valid, .out_stall, .granted_address, .status,
        .entries_used, .peak_entries, .lost_events, .lost_bytes,
        .free_bytes_total, .cmd, .rd_start, .rd_size
    );

    ffa_table u_table (
        .clk, .cmd, .rd_start, .rd_size
    );

    `FFA_ASSERT(a_count_range, (entries_used <= 7'(TableEntries)), "entry count over range")
    `FFA_ASSERT(a_peak_ge_count, (peak_entries >= entries_used), "peak below count")
    `FFA_IMPLY(a_busy_while_out, out_valid, in_stall, "input taken with result pending")
    `FFA_IMPLY(a_grant_ok, out_valid && granted_address != 32'd0, status == ST_OK,
               "grant with failure status")
endmodule

// ===== bench/first_fit_free_list_allocator_top_test.sv =====
module first_fit_free_list_allocator_top_test;
    import ffa_pkg::*;

    // One expected result beat: what the allocator should report for one request.
    typedef struct {
        logic [31:0] grant;
        status_t     stat;
        logic [6:0]  used;
        logic [6:0]  peak;
        logic [31:0] lost_cnt;
        logic [31:0] lost_sum;
        logic [31:0] free_sum;
    } alloc_report_t;

    // Scoreboard: holds its own copy of the sorted free table, predicts each
    // report when a request beat is taken, and checks each report beat.
    class extent_table_sb;
        logic [31:0]   ext_start [TableEntries];
        logic [31:0]   ext_size  [TableEntries];
        int            n_used;
        int            n_peak;
        logic [31:0]   lost_cnt;
        logic [31:0]   lost_sum;
        logic [31:0]   free_sum;
        alloc_report_t reports_due [$];
        int            n_errors;

        function void drop_entry(int pos);
            n_used--;
            for (int j = pos; j < n_used; j++)
            begin
                ext_start[j] = ext_start[j + 1];
                ext_size[j]  = ext_size[j + 1];
            end
        endfunction

        function status_t carve(logic [31:0] need, output logic [31:0] grant);
            grant = '0;
            for (int i = 0; i < n_used; i++)
            begin
                if (ext_size[i] >= need)
                begin
                    grant        = ext_start[i];
                    ext_start[i] = ext_start[i] + need;
                    ext_size[i]  = ext_size[i] - need;
                    free_sum     = free_sum - need;
                    if (ext_size[i] == 0)
                        drop_entry(i);
                    return ST_OK;
                end
            end
            return ST_NOFIT;
        endfunction

        function status_t give_back(logic [31:0] addr, logic [31:0] size);
            int i;
            for (i = 0; i < n_used; i++)
                if (ext_start[i] > addr)
                    break;
            // merge into lower neighbor, possibly bridging to the upper one
            if (i > 0 && ext_start[i - 1] + ext_size[i - 1] == addr)
            begin
                ext_size[i - 1] = ext_size[i - 1] + size;
                free_sum        = free_sum + size;
                if (i < n_used && addr + size == ext_start[i])
                begin
                    ext_size[i - 1] = ext_size[i - 1] + ext_size[i];
                    drop_entry(i);
                end
                return ST_OK;
            end
            if (i < n_used && addr + size == ext_start[i])
            begin
                ext_start[i] = addr;
                ext_size[i]  = ext_size[i] + size;
                free_sum     = free_sum + size;
                return ST_OK;
            end
            if (n_used < TableEntries)
            begin
                for (int k = n_used; k > i; k--)
                begin
                    ext_start[k] = ext_start[k - 1];
                    ext_size[k]  = ext_size[k - 1];
                end
                n_used++;
                if (n_peak < n_used)
                    n_peak = n_used;
                ext_start[i] = addr;
                ext_size[i]  = size;
                free_sum     = free_sum + size;
                return ST_OK;
            end
            // table full: extent is lost, counters saturate
            if (lost_cnt != 32'hFFFF_FFFF)
                lost_cnt++;
            if (32'hFFFF_FFFF - lost_sum < size)
                lost_sum = 32'hFFFF_FFFF;
            else
                lost_sum = lost_sum + size;
            return ST_LOST;
        endfunction

        function void note_request(op_t op, logic [31:0] addr, logic [31:0] cnt);
            alloc_report_t r;
            r.grant = '0;
            r.stat  = ST_OK;
            case (op)
                OP_ALLOC: r.stat = carve(cnt, r.grant);
                OP_FREE:  r.stat = give_back(addr, cnt);
                OP_CLEAR:
                begin
                    n_used   = 0;
                    n_peak   = 0;
                    lost_cnt = '0;
                    lost_sum = '0;
                    free_sum = '0;
                end
                default: ;
            endcase
            r.used     = 7'(n_used);
            r.peak     = 7'(n_peak);
            r.lost_cnt = lost_cnt;
            r.lost_sum = lost_sum;
            r.free_sum = free_sum;
            reports_due.push_back(r);
        endfunction

        function void check_report(logic [31:0] grant, logic [1:0] stat, logic [6:0] used,
                                   logic [6:0] peak, logic [31:0] lcnt, logic [31:0] lsum,
                                   logic [31:0] fsum);
            alloc_report_t r;
            if (reports_due.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result beat at %0t", $time);
                return;
            end
            r = reports_due.pop_front();
            if (grant !== r.grant || stat !== r.stat || used !== r.used || peak !== r.peak ||
                lcnt !== r.lost_cnt || lsum !== r.lost_sum || fsum !== r.free_sum)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display({"mismatch at %0t: exp grant=%h st=%0d used=%0d peak=%0d ",
                              "lost=%h/%h free=%h, got grant=%h st=%0d used=%0d ",
                              "peak=%0d lost=%h/%h free=%h"},
                             $time, r.grant, r.stat, r.used, r.peak, r.lost_cnt, r.lost_sum,
                             r.free_sum, grant, stat, used, peak, lcnt, lsum, fsum);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = OP_ALLOC;
    logic [31:0] extent_address = '0;
    logic [31:0] byte_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] granted_address;
    logic [1:0]  status;
    logic [6:0]  entries_used;
    logic [6:0]  peak_entries;
    logic [31:0] lost_events;
    logic [31:0] lost_bytes;
    logic [31:0] free_bytes_total;

    extent_table_sb sb = new();
    bit quiet_tail = 1'b0;   // no idling on either side near the end

    first_fit_free_list_allocator_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .extent_address  (extent_address),
        .byte_count      (byte_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .granted_address (granted_address),
        .status          (status),
        .entries_used    (entries_used),
        .peak_entries    (peak_entries),
        .lost_events     (lost_events),
        .lost_bytes      (lost_bytes),
        .free_bytes_total(free_bytes_total)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop; leaves room for the worst-case request time plus stall bursts.
    initial
    begin
        #200_000_000;
        $display("** first_fit_free_list_allocator_top: FAILED **");
        $finish;
    end

    // Result side: random stall bursts, with quiet stretches in between.
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 16);
            out_stall <= (hold > 0);
        end
    end

    // Results are sampled at the rising edge, before the block updates.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_report(granted_address, status, entries_used, peak_entries,
                                lost_events, lost_bytes, free_bytes_total);
        end
    end

    // Drive one request beat; holds until taken. An idle burst may come first,
    // in which case valid drops for that burst.
    task automatic send_request(op_t op, logic [31:0] addr, logic [31:0] cnt);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        operation      <= op;
        extent_address <= addr;
        byte_count     <= cnt;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        sb.note_request(op, addr, cnt);
        @(negedge clk);
    endtask

    // Random request, mostly well-formed: frees that touch existing extents,
    // fresh frees in open space, allocations sized from the table.
    task automatic random_request();
        int r;
        int e;
        logic [31:0] a;
        logic [31:0] c;
        r = $urandom_range(0, 299);
        c = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4096);
        e = (sb.n_used > 0) ? $urandom_range(0, sb.n_used - 1) : 0;
        if (r == 0)
            send_request(OP_CLEAR, $urandom, $urandom);
        else if (r < 3)
            send_request(OP_RSVD, $urandom, $urandom);
        else if (r < 110)
        begin
            // exact fit on a table entry removes it; otherwise carve or miss
            if (sb.n_used > 0 && $urandom_range(0, 2) == 0)
                c = sb.ext_size[e];
            else if ($urandom_range(0, 1) == 0)
                c = $urandom_range(0, 512);
            send_request(OP_ALLOC, $urandom, c);
        end
        else if (r < 160 && sb.n_used > 0)
        begin
            // extend an extent upward; may also bridge to the next one
            a = sb.ext_start[e] + sb.ext_size[e];
            if (e + 1 < sb.n_used && $urandom_range(0, 1) == 0)
                c = sb.ext_start[e + 1] - a;
            send_request(OP_FREE, a, c);
        end
        else if (r < 190 && sb.n_used > 0)
            send_request(OP_FREE, sb.ext_start[e] - c, c);
        else
            send_request(OP_FREE, $urandom, c);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty table, zero-size extents, merges, wrap, extremes
        send_request(OP_ALLOC, 32'h0, 32'd10);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_FREE, 32'h0, 32'd0);
        send_request(OP_ALLOC, 32'h0, 32'd0);
        send_request(OP_FREE, 32'd100, 32'd50);
        send_request(OP_FREE, 32'd200, 32'd50);
        send_request(OP_FREE, 32'd150, 32'd50);
        send_request(OP_ALLOC, 32'h0, 32'd0);
        send_request(OP_FREE, 32'd90, 32'd10);
        send_request(OP_FREE, 32'd250, 32'd6);
        send_request(OP_ALLOC, 32'h0, 32'd166);
        send_request(OP_FREE, 32'hFFFF_FFF0, 32'h20);
        send_request(OP_FREE, 32'h10, 32'h8);
        send_request(OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'h0, 32'h10);
        send_request(OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_CLEAR, 32'h0, 32'h0);
        // fill the table with isolated extents, then lose a few large ones
        for (int n = 0; n < 64; n++)
            send_request(OP_FREE, 32'h1000 * (2 * n + 1), 32'h100);
        send_request(OP_FREE, 32'hFFFF_0000, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'hFFFF_0000, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'h0, 32'd0);
        send_request(OP_CLEAR, 32'h0, 32'h0);

        for (int n = 0; n < 1300; n++)
        begin
            if (n == 1150)
                quiet_tail = 1'b1;
            random_request();
        end
        in_valid <= 1'b0;

        while (sb.reports_due.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.n_errors == 0)
            $display("** first_fit_free_list_allocator_top: PASSED **");
        else
            $display("** first_fit_free_list_allocator_top: FAILED **");
        $finish;
    end
endmodule
